[hdl/pcsd_pkg.sv]
package pcsd_pkg;

  localparam int ValW      = 10;
  localparam int FrameW    = 23;
  localparam int LenW      = 5;
  localparam int SegW      = 7;
  localparam int DigitW    = 4;
  localparam int CfgIdxW   = 1;
  localparam int MaxFrames = 4;
  localparam int SlotW     = $clog2(MaxFrames);
  localparam int QDepth    = 2;
  localparam int QPtrW     = $clog2(QDepth);

  localparam logic [ValW-1:0]   WrapLimitRst = 10'd999;
  localparam logic [ValW-1:0]   SatLimitRst  = 10'd10;
  localparam logic [LenW-1:0]   NumLen       = 5'd23;
  localparam logic [LenW-1:0]   BlankLen     = 5'd7;
  localparam logic [FrameW-1:0] BlankBits    = 23'h00007F;

  // divide by ten: (v * 205) >> 11 is exact for v below 1029
  localparam int Radix    = 10;
  localparam int Recip10  = 205;
  localparam int RecipSh  = 11;
  localparam int Q1W      = 7;
  localparam int Q2W      = 4;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WRAP_LIMIT = 1'b0,
    CFG_SAT_LIMIT  = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    TRK_IDLE,
    TRK_LOW,
    TRK_HIGH
  } trk_e;

  typedef struct packed {
    trk_e nxt;
    logic fire;
  } trk_t;

  typedef logic [ValW-1:0] val_t;

  typedef struct packed {
    val_t value;
    logic led;
    logic blank;
  } frm_t;

  typedef struct packed {
    frm_t [MaxFrames-1:0] frm;
    logic [SlotW-1:0]     last_slot;
  } job_t;

  function automatic trk_t track(trk_e st, logic lvl);
    trk_t r;
    r.fire = 1'b0;
    case (st)
      TRK_IDLE: r.nxt = lvl ? TRK_IDLE : TRK_LOW;
      TRK_LOW:  r.nxt = lvl ? TRK_HIGH : TRK_LOW;
      TRK_HIGH: begin
        if (lvl) begin
          r.nxt = TRK_HIGH;
        end else begin
          r.nxt  = TRK_IDLE;
          r.fire = 1'b1;
        end
      end
      default:  r.nxt = TRK_IDLE;
    endcase
    return r;
  endfunction

  // active low, bit 0 sent first, order g f e d c b a
  function automatic logic [SegW-1:0] seg_code(logic [DigitW-1:0] d);
    logic [SegW-1:0] s;
    case (d)
      4'd0:    s = 7'h01;
      4'd1:    s = 7'h4F;
      4'd2:    s = 7'h12;
      4'd3:    s = 7'h06;
      4'd4:    s = 7'h4C;
      4'd5:    s = 7'h24;
      4'd6:    s = 7'h20;
      4'd7:    s = 7'h0F;
      4'd8:    s = 7'h00;
      4'd9:    s = 7'h04;
      default: s = 7'h7F;
    endcase
    return s;
  endfunction

endpackage

[hdl/pcsd_if.sv]
interface pcsd_in_if;
  logic valid;
  logic ready;
  logic run;
  logic wrap_mode;
  logic limit_mode;
  logic pulse_level;
  logic clear;

  modport source (output valid, run, wrap_mode, limit_mode, pulse_level, clear,
                  input ready);
  modport sink (input valid, run, wrap_mode, limit_mode, pulse_level, clear,
                output ready);
endinterface

interface pcsd_out_if;
  logic        valid;
  logic        ready;
  logic [22:0] frame_bits;
  logic [4:0]  frame_length;
  logic [9:0]  shown_value;
  logic        limit_led;
  logic        last;

  modport source (output valid, frame_bits, frame_length, shown_value, limit_led, last,
                  input ready);
  modport sink (input valid, frame_bits, frame_length, shown_value, limit_led, last,
                output ready);
endinterface

[hdl/pcsd_front.sv]
module pcsd_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [pcsd_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [pcsd_pkg::ValW-1:0]    cfg_data_i,
  pcsd_in_if.sink                      in_w,
  input  logic                         full_i,
  output logic                         push_o,
  output pcsd_pkg::job_t               job_o
);
  import pcsd_pkg::*;

  val_t wlim_q, slim_q;
  val_t wcnt_q, wcnt_d, lcnt_q, lcnt_d;
  trk_e wtrk_q, wtrk_d, ltrk_q, ltrk_d;
  logic led_q, led_d;
  logic acc;
  trk_t wt, lt;
  logic [ValW:0] wnext, lsum;
  logic [SlotW:0] n, nm1;
  job_t job;

  assign in_w.ready = !full_i;
  assign acc = in_w.valid && in_w.ready;

  always_comb begin
    wt     = track(wtrk_q, in_w.pulse_level);
    lt     = track(ltrk_q, in_w.pulse_level);
    wnext  = {1'b0, wcnt_q} + {{ValW{1'b0}}, 1'b1};
    lsum   = {1'b0, lcnt_q} + {{ValW{1'b0}}, lt.fire};
    wcnt_d = wcnt_q;
    lcnt_d = lcnt_q;
    wtrk_d = wtrk_q;
    ltrk_d = ltrk_q;
    led_d  = led_q;
    job    = '0;
    n      = '0;
    if (in_w.run) begin
      if (in_w.wrap_mode) begin
        wtrk_d = wt.nxt;
        if (wt.fire) begin
          wcnt_d = (wnext > {1'b0, wlim_q}) ? '0 : wnext[ValW-1:0];
        end
        led_d = 1'b1;
        job.frm[n[SlotW-1:0]] = '{value: wcnt_d, led: 1'b1, blank: 1'b0};
        n = n + 1'b1;
        if (in_w.clear) begin
          wcnt_d = '0;
          wtrk_d = TRK_IDLE;
          job.frm[n[SlotW-1:0]] = '{value: '0, led: 1'b1, blank: 1'b0};
          n = n + 1'b1;
        end
      end
      if (in_w.limit_mode) begin
        ltrk_d = lt.nxt;
        if (lsum < {1'b0, slim_q}) begin
          lcnt_d = lsum[ValW-1:0];
          led_d  = 1'b1;
        end else begin
          lcnt_d = slim_q;
          led_d  = 1'b0;
        end
        job.frm[n[SlotW-1:0]] = '{value: lcnt_d, led: led_d, blank: 1'b0};
        n = n + 1'b1;
        if (in_w.clear) begin
          lcnt_d = '0;
          ltrk_d = TRK_IDLE;
          job.frm[n[SlotW-1:0]] = '{value: '0, led: led_d, blank: 1'b0};
          n = n + 1'b1;
        end
      end
    end else if (in_w.limit_mode) begin
      led_d = 1'b0;
      job.frm[n[SlotW-1:0]] = '{value: '0, led: 1'b0, blank: 1'b1};
      n = n + 1'b1;
    end
    nm1 = n - 1'b1;
    job.last_slot = nm1[SlotW-1:0];
  end

  assign push_o = acc && (n != '0);
  assign job_o  = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlim_q <= WrapLimitRst;
      slim_q <= SatLimitRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WRAP_LIMIT: wlim_q <= cfg_data_i;
        CFG_SAT_LIMIT:  slim_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wcnt_q <= '0;
      lcnt_q <= '0;
      wtrk_q <= TRK_IDLE;
      ltrk_q <= TRK_IDLE;
      led_q  <= 1'b0;
    end else if (acc) begin
      wcnt_q <= wcnt_d;
      lcnt_q <= lcnt_d;
      wtrk_q <= wtrk_d;
      ltrk_q <= ltrk_d;
      led_q  <= led_d;
    end
  end

endmodule

[hdl/pcsd_queue.sv]
module pcsd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  pcsd_pkg::job_t job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output pcsd_pkg::job_t head_o
);
  import pcsd_pkg::*;

  job_t mem_q [QDepth];
  logic [QPtrW-1:0] wptr_q, rptr_q;
  logic [QPtrW:0]   cnt_q;

  assign full_o  = (cnt_q == (QPtrW+1)'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

[hdl/pcsd_back.sv]
module pcsd_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  pcsd_pkg::job_t head_i,
  output logic           pop_o,
  pcsd_out_if.source     out_w
);
  import pcsd_pkg::*;

  localparam int P1W = ValW + 8;
  localparam int P2W = Q1W + 8;

  logic [SlotW-1:0] slot_q;
  logic en, issue, is_last;
  frm_t cur;
  logic [P1W-1:0] prod1;
  logic [P2W-1:0] prod2;

  logic          s1_valid_q, s1_last_q;
  frm_t          s1_frm_q;
  logic [Q1W-1:0] s1_q1_q;

  logic            s2_valid_q, s2_last_q;
  frm_t            s2_frm_q;
  logic [Q1W-1:0]  s2_q1_q;
  logic [Q2W-1:0]  s2_q2_q;
  logic [DigitW-1:0] s2_units_q;
  logic [ValW-1:0] units_full;

  logic [Q1W-1:0]    tens_full;
  logic [DigitW-1:0] hund;
  logic [FrameW-1:0] num_bits;
  logic [SegW-1:0]   su, st, sh;

  logic              out_valid_q, out_last_q, out_led_q;
  logic [FrameW-1:0] out_bits_q;
  logic [LenW-1:0]   out_len_q;
  val_t              out_val_q;

  assign en      = !out_valid_q || out_w.ready;
  assign issue   = en && !empty_i;
  assign cur     = head_i.frm[slot_q];
  assign is_last = (slot_q == head_i.last_slot);
  assign pop_o   = issue && is_last;

  assign prod1      = {8'b0, cur.value} * P1W'(Recip10);
  assign prod2      = {8'b0, s1_q1_q} * P2W'(Recip10);
  assign units_full = s1_frm_q.value - ValW'(s1_q1_q) * ValW'(Radix);
  assign tens_full  = s2_q1_q - Q1W'(s2_q2_q) * Q1W'(Radix);
  assign hund       = (s2_q2_q == DigitW'(Radix)) ? '0 : s2_q2_q;
  assign su         = seg_code(s2_units_q);
  assign st         = seg_code(tens_full[DigitW-1:0]);
  assign sh         = seg_code(hund);
  assign num_bits   = {sh, st[SegW-1], st, su[SegW-1], su};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q      <= '0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      if (issue) begin
        slot_q <= is_last ? '0 : slot_q + 1'b1;
      end
      s1_valid_q  <= issue;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_frm_q   <= cur;
      s1_last_q  <= is_last;
      s1_q1_q    <= prod1[RecipSh +: Q1W];
      s2_frm_q   <= s1_frm_q;
      s2_last_q  <= s1_last_q;
      s2_q1_q    <= s1_q1_q;
      s2_q2_q    <= prod2[RecipSh +: Q2W];
      s2_units_q <= units_full[DigitW-1:0];
      out_last_q <= s2_last_q;
      out_led_q  <= s2_frm_q.led;
      out_val_q  <= s2_frm_q.value;
      if (s2_frm_q.blank) begin
        out_bits_q <= BlankBits;
        out_len_q  <= BlankLen;
      end else begin
        out_bits_q <= num_bits;
        out_len_q  <= NumLen;
      end
    end
  end

  assign out_w.valid        = out_valid_q;
  assign out_w.frame_bits   = out_bits_q;
  assign out_w.frame_length = out_len_q;
  assign out_w.shown_value  = out_val_q;
  assign out_w.limit_led    = out_led_q;
  assign out_w.last         = out_last_q;

endmodule

[hdl/pulse_counter_segment_shift_display.sv]
// channel  | dir | handshake     | word
// in_w     | in  | valid / ready | run, wrap_mode, limit_mode, pulse_level, clear
// out_w    | out | valid / ready | frame_bits, frame_length, shown_value, limit_led, last
// cfg      | in  | cfg_we_i      | cfg_idx_i, cfg_data_i
// the front takes one word a cycle while the job queue has room, updates the
// counters at once and queues at most one job of up to four frames per word
// the back issues one frame a cycle while the output is not stalled; a word yields 0 to 4 frames
// a word's frames pass through the job queue and the s1, s2 and output registers
// reset clears counters, trackers, led and queue; limits return to 999 and 10
// a stalled output freezes the back pipeline, the front stalls only when the queue is full
module pulse_counter_segment_shift_display (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [pcsd_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [pcsd_pkg::ValW-1:0]    cfg_data_i,
  pcsd_in_if.sink                      in_w,
  pcsd_out_if.source                   out_w
);
  import pcsd_pkg::*;

  logic push, full, pop, empty;
  job_t job, head;

  pcsd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_w       (in_w),
    .full_i     (full),
    .push_o     (push),
    .job_o      (job)
  );

  pcsd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head)
  );

  pcsd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .head_i  (head),
    .pop_o   (pop),
    .out_w   (out_w)
  );

endmodule

[sim/tb_pulse_counter_segment_shift_display.sv]
module tb_pulse_counter_segment_shift_display;
  timeunit 1ns;
  timeprecision 1ps;

  import pcsd_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int HoldCycles = 80;
  localparam int SettleCycles = 10;
  localparam int PhaseWords = 41;
  localparam logic [6:0] SEG_LUT [10] = '{
    7'h01, 7'h4F, 7'h12, 7'h06, 7'h4C, 7'h24, 7'h20, 7'h0F, 7'h00, 7'h04
  };

  typedef struct packed {
    logic run;
    logic wrap_mode;
    logic limit_mode;
    logic level;
    logic clear;
  } sample_t;

  typedef struct packed {
    logic [FrameW-1:0] bits;
    logic [LenW-1:0]   len;
    val_t              value;
    logic              led;
    logic              last;
  } frame_t;

  typedef enum logic {
    ROW_WORD,
    ROW_REG
  } row_kind_e;

  typedef struct packed {
    row_kind_e kind;
    cfg_idx_e  idx;
    val_t      data;
    sample_t   word;
    logic      typed;
    frame_t    want;
  } row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  cfg_idx_e cfg_idx_i;
  val_t cfg_data_i;

  pcsd_in_if  in_w ();
  pcsd_out_if out_w ();

  pulse_counter_segment_shift_display u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_w       (in_w),
    .out_w      (out_w)
  );

  // predicted state of the counter sections
  val_t wrap_lim;
  val_t sat_lim;
  val_t wrap_cnt;
  val_t lim_cnt;
  trk_e wrap_trk;
  trk_e lim_trk;
  logic led;

  frame_t pending_frames [$];
  frame_t head_frame;
  row_t script [$];

  int mismatch_cnt;
  int cycle_cnt;
  int idle_pct;
  int stall_pct;
  int hold_left;
  logic hold_go;
  logic hold_seen;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic pulse_done(inout trk_e st, input logic lvl);
    logic fire;
    fire = 1'b0;
    case (st)
      TRK_IDLE: if (!lvl) st = TRK_LOW;
      TRK_LOW:  if (lvl) st = TRK_HIGH;
      TRK_HIGH: begin
        if (!lvl) begin
          st = TRK_IDLE;
          fire = 1'b1;
        end
      end
      default:  st = TRK_IDLE;
    endcase
    return fire;
  endfunction

  function automatic frame_t number_frame(val_t v, logic l);
    frame_t f;
    logic [6:0] u;
    logic [6:0] t;
    logic [6:0] h;
    u = SEG_LUT[v % 10];
    t = SEG_LUT[(v / 10) % 10];
    h = SEG_LUT[(v / 100) % 10];
    f.bits = {h, t[6], t, u[6], u};
    f.len = NumLen;
    f.value = v;
    f.led = l;
    f.last = 1'b0;
    return f;
  endfunction

  task automatic predict_frames(input sample_t w, input logic typed, input frame_t want);
    frame_t outs [4];
    int n;
    logic [ValW:0] nxt;
    n = 0;
    if (w.run) begin
      if (w.wrap_mode) begin
        if (pulse_done(wrap_trk, w.level)) begin
          if (wrap_cnt >= wrap_lim || wrap_cnt == '1) wrap_cnt = '0;
          else wrap_cnt = wrap_cnt + 1'b1;
        end
        led = 1'b1;
        outs[n] = number_frame(wrap_cnt, led);
        n++;
        if (w.clear) begin
          wrap_cnt = '0;
          wrap_trk = TRK_IDLE;
          outs[n] = number_frame('0, led);
          n++;
        end
      end
      if (w.limit_mode) begin
        nxt = {1'b0, lim_cnt} + pulse_done(lim_trk, w.level);
        if (nxt < {1'b0, sat_lim}) begin
          lim_cnt = nxt[ValW-1:0];
          led = 1'b1;
        end else begin
          lim_cnt = sat_lim;
          led = 1'b0;
        end
        outs[n] = number_frame(lim_cnt, led);
        n++;
        if (w.clear) begin
          lim_cnt = '0;
          lim_trk = TRK_IDLE;
          outs[n] = number_frame('0, led);
          n++;
        end
      end
    end else if (w.limit_mode) begin
      led = 1'b0;
      outs[n] = {BlankBits, BlankLen, val_t'(0), 1'b0, 1'b0};
      n++;
    end
    if (n > 0) outs[n-1].last = 1'b1;
    if (typed) begin
      pending_frames.push_back(want);
    end else begin
      for (int i = 0; i < n; i++) pending_frames.push_back(outs[i]);
    end
  endtask

  task automatic send_word(input sample_t w, input logic typed, input frame_t want);
    while ($urandom_range(99) < idle_pct) begin
      in_w.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_w.valid       <= 1'b1;
    in_w.run         <= w.run;
    in_w.wrap_mode   <= w.wrap_mode;
    in_w.limit_mode  <= w.limit_mode;
    in_w.pulse_level <= w.level;
    in_w.clear       <= w.clear;
    @(posedge clk_i);
    while (!in_w.ready) @(posedge clk_i);
    predict_frames(w, typed, want);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input val_t data);
    in_w.valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    if (idx == CFG_WRAP_LIMIT) wrap_lim = data;
    else sat_lim = data;
    cfg_we_i <= 1'b0;
  endtask

  function automatic row_t word_row(logic run, logic wm, logic lm, logic lvl, logic clr,
                                    logic typed = 1'b0, frame_t want = '0);
    row_t r;
    r = '0;
    r.kind = ROW_WORD;
    r.word = {run, wm, lm, lvl, clr};
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  function automatic row_t reg_row(cfg_idx_e idx, val_t data);
    row_t r;
    r = '0;
    r.kind = ROW_REG;
    r.idx = idx;
    r.data = data;
    return r;
  endfunction

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_go != hold_seen) begin
      hold_seen <= hold_go;
      hold_left <= HoldCycles;
      out_w.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_w.ready <= 1'b0;
    end else begin
      out_w.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (out_w.valid === 1'b1 && out_w.ready === 1'b1) begin
      if (pending_frames.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected word: bits %h len %0d value %0d led %b last %b",
                   out_w.frame_bits, out_w.frame_length, out_w.shown_value,
                   out_w.limit_led, out_w.last);
      end else begin
        head_frame = pending_frames.pop_front();
        if (out_w.frame_bits !== head_frame.bits || out_w.frame_length !== head_frame.len ||
            out_w.shown_value !== head_frame.value || out_w.limit_led !== head_frame.led ||
            out_w.last !== head_frame.last) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t word mismatch: bits %h/%h len %0d/%0d value %0d/%0d led %b/%b last %b/%b",
                     $time, head_frame.bits, out_w.frame_bits, head_frame.len,
                     out_w.frame_length, head_frame.value, out_w.shown_value,
                     head_frame.led, out_w.limit_led, head_frame.last, out_w.last);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    val_t wrap_set [8];
    val_t sat_set [8];
    sample_t w;
    logic prev_level;
    wrap_set = '{10'd999, 10'd5, 10'd1, 10'd0, 10'd1023, 10'd20, 10'd3, 10'd999};
    sat_set  = '{10'd10, 10'd3, 10'd1, 10'd0, 10'd1023, 10'd999, 10'd7, 10'd10};
    prev_level = 1'b0;

    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_WRAP_LIMIT;
    cfg_data_i = '0;
    in_w.valid = 1'b0;
    in_w.run = 1'b0;
    in_w.wrap_mode = 1'b0;
    in_w.limit_mode = 1'b0;
    in_w.pulse_level = 1'b0;
    in_w.clear = 1'b0;
    out_w.ready = 1'b0;
    hold_go = 1'b0;
    hold_seen = 1'b0;
    hold_left = 0;
    idle_pct = 0;
    stall_pct = 0;
    mismatch_cnt = 0;
    cycle_cnt = 0;

    wrap_lim = WrapLimitRst;
    sat_lim = SatLimitRst;
    wrap_cnt = '0;
    lim_cnt = '0;
    wrap_trk = TRK_IDLE;
    lim_trk = TRK_IDLE;
    led = 1'b0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part: run off, each mode, pulses, wraps, ceilings, clears
    script.push_back(word_row(0, 0, 0, 0, 0));
    script.push_back(word_row(0, 1, 1, 1, 1, 1'b1,
                              {BlankBits, BlankLen, val_t'(0), 1'b0, 1'b1}));
    script.push_back(word_row(1, 1, 0, 1, 0, 1'b1,
                              {23'h010101, NumLen, val_t'(0), 1'b1, 1'b1}));
    script.push_back(word_row(1, 1, 1, 0, 0));
    script.push_back(word_row(1, 1, 1, 1, 0));
    script.push_back(word_row(1, 1, 1, 0, 0));
    script.push_back(word_row(1, 0, 0, 1, 0));
    script.push_back(reg_row(CFG_WRAP_LIMIT, 10'd1));
    script.push_back(word_row(1, 1, 0, 0, 0));
    script.push_back(word_row(1, 1, 0, 1, 0));
    script.push_back(word_row(1, 1, 0, 0, 0));
    script.push_back(reg_row(CFG_SAT_LIMIT, 10'd1));
    script.push_back(word_row(1, 0, 1, 0, 0));
    script.push_back(word_row(1, 0, 1, 1, 0));
    script.push_back(word_row(1, 0, 1, 0, 0));
    script.push_back(word_row(1, 0, 1, 1, 1));
    script.push_back(reg_row(CFG_SAT_LIMIT, 10'd0));
    script.push_back(word_row(1, 0, 1, 1, 0, 1'b1,
                              {23'h010101, NumLen, val_t'(0), 1'b0, 1'b1}));
    script.push_back(reg_row(CFG_WRAP_LIMIT, 10'd0));
    script.push_back(word_row(1, 1, 0, 0, 0));
    script.push_back(word_row(1, 1, 0, 1, 0));
    script.push_back(word_row(1, 1, 0, 0, 0));
    script.push_back(reg_row(CFG_WRAP_LIMIT, 10'd999));
    script.push_back(reg_row(CFG_SAT_LIMIT, 10'd1023));
    script.push_back(word_row(1, 1, 1, 0, 1));
    script.push_back(word_row(1, 1, 1, 1, 1));

    foreach (script[i]) begin
      if (script[i].kind == ROW_REG) write_reg(script[i].idx, script[i].data);
      else send_word(script[i].word, script[i].typed, script[i].want);
    end

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_WRAP_LIMIT, wrap_set[ph]);
      write_reg(CFG_SAT_LIMIT, sat_set[ph]);
      case (ph % 4)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
          hold_go <= ~hold_go;
        end
        1: begin
          idle_pct = 47;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 47;
        end
        default: begin
          idle_pct = 9;
          stall_pct = 9;
        end
      endcase
      repeat (PhaseWords) begin
        // mostly clean low-high-low trains, some noise
        w.run = ($urandom_range(99) < 88);
        w.wrap_mode = 1'($urandom_range(1));
        w.limit_mode = 1'($urandom_range(1));
        w.level = ($urandom_range(99) < 70) ? ~prev_level : 1'($urandom_range(1));
        w.clear = ($urandom_range(99) < 7);
        prev_level = w.level;
        send_word(w, 1'b0, '0);
      end
    end

    in_w.valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_frames.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
